/* rtl/bb3_pkg.sv */
// Shared constants, types and function of the 3x3 box blur core.
package bb3_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_INDEX_BITS  = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

   // Largest channel sum over nine pixels needs 12 bits; count needs 4.
   localparam int SUM_BITS = 12;
   localparam int CNT_BITS = 4;

   typedef logic [23:0] pixel_type;

   // Word handed from the front end to the averaging back end.
   typedef struct packed {
      logic [SUM_BITS-1:0] sum_red;
      logic [SUM_BITS-1:0] sum_green;
      logic [SUM_BITS-1:0] sum_blue;
      logic [CNT_BITS-1:0] count;
      logic                row_end;
      logic                frame_end;
   } job_type;

   localparam int JOB_BITS = 3 * SUM_BITS + CNT_BITS + 2;

   // Rounded mean of a channel sum over 1, 2, 3, 4, 6 or 9 pixels, done as a
   // multiply by a scaled reciprocal (2^16 scale) with the exact quotient
   // guaranteed for sums below 2^12.
   function automatic logic [7:0] round_mean(input logic [SUM_BITS-1:0] sum,
                                             input logic [CNT_BITS-1:0] count);
      logic [SUM_BITS:0] biased;
      logic [16:0]       recip;
      logic [33:0]       prod;
      begin
         biased = {1'b0, sum} + {{(SUM_BITS-CNT_BITS+1){1'b0}}, count >> 1};
         case (count)
            4'd1:    recip = 17'd65536;
            4'd2:    recip = 17'd32768;
            4'd3:    recip = 17'd21846;
            4'd4:    recip = 17'd16384;
            4'd6:    recip = 17'd10923;
            4'd9:    recip = 17'd7282;
            default: recip = 17'd65536;
         endcase
         prod = {21'd0, biased} * {17'd0, recip};
         round_mean = prod[23:16];
      end
   endfunction

endpackage

/* rtl/bb3_front.sv */
// Front end: line stores, window, position counters and neighborhood sums.
module bb3_front #(
   parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   restart,
   input  logic [bb3_pkg::WIDTH_REG_BITS-1:0]     frame_width,
   input  logic [bb3_pkg::HEIGHT_REG_BITS-1:0]    frame_height,
   input  logic                                   item_valid,
   input  logic                                   item_mode,
   input  bb3_pkg::pixel_type                     item_pixel,
   output logic                                   job_valid,
   output bb3_pkg::job_type                       job
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int CNT_W    = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
   localparam int WR_BITS  = (bb3_pkg::WIDTH_REG_BITS > CNT_W) ? bb3_pkg::WIDTH_REG_BITS : CNT_W;
   localparam int HR_BITS  = (bb3_pkg::HEIGHT_REG_BITS > ROW_W) ? bb3_pkg::HEIGHT_REG_BITS : ROW_W;

   // Clamp the register values to the supported frame size.
   logic [CNT_W-1:0] width_c;
   logic [ROW_W-1:0] height_c;
   logic [WR_BITS-1:0] width_x;
   logic [HR_BITS-1:0] height_x;
   always_comb begin
      width_x  = WR_BITS'(frame_width);
      height_x = HR_BITS'(frame_height);
      if (width_x == '0)
         width_c = CNT_W'(1);
      else if (width_x > WR_BITS'(MAX_WIDTH))
         width_c = CNT_W'(MAX_WIDTH);
      else
         width_c = CNT_W'(width_x);
      if (height_x == '0)
         height_c = ROW_W'(1);
      else if (height_x > HR_BITS'(MAX_HEIGHT))
         height_c = ROW_W'(MAX_HEIGHT);
      else
         height_c = ROW_W'(height_x);
   end

   logic [CNT_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;

   logic drain, step, emit, fire;
   assign drain = in_row_ff >= height_c;
   assign step  = item_valid && (drain || !item_mode);
   assign emit  = (in_row_ff >= ROW_W'(2)) || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
   assign fire  = step && emit && (out_row_ff < height_c);

   // Line stores: read at the tick's column with registered data and written
   // back in the next cycle. A read of the column still being written (a frame
   // one pixel wide) takes the data that is being written.
   bb3_pkg::pixel_type upper_mem [MAX_WIDTH];
   bb3_pkg::pixel_type middle_mem [MAX_WIDTH];
   bb3_pkg::pixel_type top_rd_ff, mid_rd_ff;
   bb3_pkg::pixel_type bot_ff;
   logic [COL_BITS-1:0] col_addr, wr_col_ff;
   logic wr_ff, hit;
   bb3_pkg::pixel_type bot;
   assign col_addr = in_col_ff[COL_BITS-1:0];
   assign bot = drain ? '0 : item_pixel;
   assign hit = wr_ff && (wr_col_ff == col_addr);

   always_ff @(posedge clock) begin
      if (step) begin
         top_rd_ff <= hit ? mid_rd_ff : upper_mem[col_addr];
         mid_rd_ff <= hit ? bot_ff : middle_mem[col_addr];
      end
      if (wr_ff) begin
         upper_mem[wr_col_ff]  <= mid_rd_ff;
         middle_mem[wr_col_ff] <= bot_ff;
      end
   end

   // Stage 1 registers: the tick's new column and the output position.
   logic s1_ff, s1_fire_ff;
   logic s1_first_ff, s1_last_ff, s1_top_ok_ff, s1_bot_ok_ff, s1_fend_ff;
   logic row_end, frame_end;
   assign row_end   = (out_col_ff + CNT_W'(1)) >= width_c;
   assign frame_end = row_end && ((out_row_ff + ROW_W'(1)) >= height_c);

   // Position counters.
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (step) begin
         if (in_col_ff + CNT_W'(1) >= width_c) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + CNT_W'(1);
         end
      end
      if (fire) begin
         if (frame_end) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (row_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         s1_ff      <= 1'b0;
         s1_fire_ff <= 1'b0;
         wr_ff      <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         s1_ff      <= step;
         s1_fire_ff <= fire;
         wr_ff      <= step && !drain;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         bot_ff       <= bot;
         wr_col_ff    <= col_addr;
         s1_first_ff  <= out_col_ff == '0;
         s1_last_ff   <= row_end;
         s1_top_ok_ff <= out_row_ff != '0;
         s1_bot_ok_ff <= (out_row_ff + ROW_W'(1)) < height_c;
         s1_fend_ff   <= frame_end;
      end
   end

   // Window: nine pixels, shifted left one column per tick.
   bb3_pkg::pixel_type win_ff [9];
   bb3_pkg::pixel_type win_in [9];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]   = win_ff[r*3+1];
         win_in[r*3+1] = win_ff[r*3+2];
      end
      win_in[2] = top_rd_ff;
      win_in[5] = mid_rd_ff;
      win_in[8] = bot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (s1_ff) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= win_in[i];
      end
   end

   // Neighborhood sums over the window as it stands after this tick.
   logic [bb3_pkg::SUM_BITS-1:0] sr, sg, sb;
   logic [bb3_pkg::CNT_BITS-1:0] cnt;
   logic ok_r, ok_c;
   always_comb begin
      sr = '0;
      sg = '0;
      sb = '0;
      cnt = '0;
      for (int dr = 0; dr < 3; dr++) begin
         for (int dc = 0; dc < 3; dc++) begin
            ok_r = !((dr == 0 && !s1_top_ok_ff) || (dr == 2 && !s1_bot_ok_ff));
            ok_c = !((dc == 0 && s1_first_ff) || (dc == 2 && s1_last_ff));
            if (ok_r && ok_c) begin
               sr  = sr + bb3_pkg::SUM_BITS'(win_in[dr*3+dc][23:16]);
               sg  = sg + bb3_pkg::SUM_BITS'(win_in[dr*3+dc][15:8]);
               sb  = sb + bb3_pkg::SUM_BITS'(win_in[dr*3+dc][7:0]);
               cnt = cnt + bb3_pkg::CNT_BITS'(1);
            end
         end
      end
   end

   // Job register toward the queue.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         job_valid <= 1'b0;
      end else begin
         job_valid <= s1_ff && s1_fire_ff;
      end
   end

   always_ff @(posedge clock) begin
      job.sum_red   <= sr;
      job.sum_green <= sg;
      job.sum_blue  <= sb;
      job.count     <= cnt;
      job.row_end   <= s1_last_ff;
      job.frame_end <= s1_fend_ff;
   end

endmodule

/* rtl/bb3_queue.sv */
// Short word queue between the front end and the averaging back end.
module bb3_queue #(
   parameter int DEPTH = 8,
   parameter int WIDTH = bb3_pkg::JOB_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [$clog2(DEPTH+1)-1:0] cnt_ff;
   logic do_pop;

   assign empty  = cnt_ff == '0;
   assign head   = mem_ff[rd_ff];
   assign level  = cnt_ff;
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
         if (do_pop) rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
         cnt_ff <= cnt_ff + (push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
      end
   end

endmodule

/* rtl/bb3_back.sv */
// Back end: divides the queued sums and passes the results on toward the result queue.
module bb3_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  bb3_pkg::job_type job,
   output logic             job_pop,
   input  logic             out_full,
   output logic             res_valid,
   output logic [25:0]      res_data
);

   // One divide stage; results land in the output queue.
   assign job_pop = job_valid && !out_full;

   always_ff @(posedge clock) begin
      if (reset) res_valid <= 1'b0;
      else       res_valid <= job_pop;
   end

   always_ff @(posedge clock) begin
      res_data <= {bb3_pkg::round_mean(job.sum_red, job.count),
                   bb3_pkg::round_mean(job.sum_green, job.count),
                   bb3_pkg::round_mean(job.sum_blue, job.count),
                   job.row_end, job.frame_end};
   end

endmodule

/* rtl/box_blur_3x3_rgb_core.sv */
// 3x3 box blur over an RGB pixel stream in raster order: one pixel per
// clock enters through push/full and blurred pixels leave through pop/empty.
// A result appears one row plus one pixel after the pixel at its center;
// after the last pixel of a frame, frame_width+1 drain words (mode 1) flush
// the remaining results. The core takes one word per cycle while full is
// low; full rises once the job queue and the result queue together hold
// ten words, which leaves room for the words still in the pipeline, so
// about ten results can wait on a stalled output side before input is held
// off. Each result passes the job queue, divide stage and result queue.
module box_blur_3x3_rgb_core #(
   parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_mode,
   input  logic [7:0]                          req_pixel_red,
   input  logic [7:0]                          req_pixel_green,
   input  logic [7:0]                          req_pixel_blue,
   output logic                                empty,
   input  logic                                pop,
   output logic [7:0]                          rsp_out_red,
   output logic [7:0]                          rsp_out_green,
   output logic [7:0]                          rsp_out_blue,
   output logic                                rsp_row_end,
   output logic                                rsp_frame_end,
   input  logic                                csr_write,
   input  logic [bb3_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bb3_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int JQ_DEPTH = 8;
   localparam int RQ_DEPTH = 16;

   // Configuration registers.
   logic [bb3_pkg::WIDTH_REG_BITS-1:0]  width_ff;
   logic [bb3_pkg::HEIGHT_REG_BITS-1:0] height_ff;
   logic restart;
   assign restart = csr_write &&
                    (csr_index == bb3_pkg::REG_FRAME_WIDTH ||
                     csr_index == bb3_pkg::REG_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bb3_pkg::WIDTH_REG_BITS'(1024);
         height_ff <= bb3_pkg::HEIGHT_REG_BITS'(768);
      end else if (csr_write) begin
         unique case (csr_index)
            bb3_pkg::REG_FRAME_WIDTH:
               width_ff <= csr_data[bb3_pkg::WIDTH_REG_BITS-1:0];
            bb3_pkg::REG_FRAME_HEIGHT:
               height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic accept;
   assign accept = push && !full;

   logic job_valid;
   bb3_pkg::job_type job_word, job_head;
   logic jq_empty, jq_pop;
   logic [$clog2(JQ_DEPTH+1)-1:0] jq_level;

   bb3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock(clock), .reset(reset), .restart(restart),
      .frame_width(width_ff), .frame_height(height_ff),
      .item_valid(accept), .item_mode(req_mode),
      .item_pixel({req_pixel_red, req_pixel_green, req_pixel_blue}),
      .job_valid(job_valid), .job(job_word)
   );

   bb3_queue #(.DEPTH(JQ_DEPTH), .WIDTH(bb3_pkg::JOB_BITS)) u_jobq (
      .clock(clock), .reset(reset), .push(job_valid), .push_data(job_word),
      .pop(jq_pop), .empty(jq_empty), .head(job_head), .level(jq_level)
   );

   logic res_valid;
   logic [25:0] res_data, rq_head;
   logic [$clog2(RQ_DEPTH+1)-1:0] rq_level;
   logic rq_full;

   // Leave room in the result queue for words still in flight.
   assign rq_full = rq_level >= ($clog2(RQ_DEPTH+1))'(RQ_DEPTH - 2);

   bb3_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(!jq_empty), .job(job_head), .job_pop(jq_pop),
      .out_full(rq_full), .res_valid(res_valid), .res_data(res_data)
   );

   bb3_queue #(.DEPTH(RQ_DEPTH), .WIDTH(26)) u_resq (
      .clock(clock), .reset(reset), .push(res_valid), .push_data(res_data),
      .pop(pop), .empty(empty), .head(rq_head), .level(rq_level)
   );

   // Hold input while the words in flight could overrun the queues.
   assign full = (32'(rq_level) + 32'(jq_level)) >= (RQ_DEPTH - 6);

   assign rsp_out_red   = rq_head[25:18];
   assign rsp_out_green = rq_head[17:10];
   assign rsp_out_blue  = rq_head[9:2];
   assign rsp_row_end   = rq_head[1];
   assign rsp_frame_end = rq_head[0];

   // The result queue never overflows.
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> rq_level < ($clog2(RQ_DEPTH+1))'(RQ_DEPTH))
      else $error("result queue overflow");

   // The job queue never overflows.
   assert property (@(posedge clock) disable iff (reset)
      job_valid |-> jq_level < ($clog2(JQ_DEPTH+1))'(JQ_DEPTH))
      else $error("job queue overflow");

   // A frame end is always also a row end.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_frame_end) |-> rsp_row_end)
      else $error("frame end without row end");

endmodule

/* test/tb_top.sv */
// Self-checking testbench of the 3x3 RGB box blur core with a scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
      bit       row_end;
      bit       frame_end;
   } blur_word_type;

   // Scoreboard: mirrors the blur datapath and queues the blurred words it predicts.
   class blur_scoreboard;
      bit [23:0] upper_row [1024];
      bit [23:0] middle_row [1024];
      bit [23:0] win [9];
      int unsigned in_col, in_row, out_col, out_row;
      bit [10:0] width_reg;
      bit [12:0] height_reg;
      blur_word_type due_words [$];
      int errors;

      function new();
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         width_reg = 11'd1024;
         height_reg = 13'd768;
         errors = 0;
         restart();
      endfunction

      function void restart();
         foreach (win[i]) win[i] = '0;
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
      endfunction

      function void write_reg(bit [bb3_pkg::CSR_INDEX_BITS-1:0] idx,
                              bit [bb3_pkg::CSR_DATA_BITS-1:0] data);
         if (idx == bb3_pkg::REG_FRAME_WIDTH) width_reg = data[10:0];
         else height_reg = data;
         restart();
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      // Note an accepted input word and predict the blurred word it releases.
      function void note_word(bit mode, bit [7:0] r, bit [7:0] g, bit [7:0] b);
         int unsigned w, h, col, n, acc[3];
         bit drain, emit, re, fe;
         bit [23:0] top, mid, bot, p;
         blur_word_type e;
         w = (width_reg == 0) ? 1 : ((width_reg > 1024) ? 1024 : width_reg);
         h = (height_reg == 0) ? 1 : ((height_reg > 4096) ? 4096 : height_reg);
         drain = in_row >= h;
         col = in_col % 1024;
         // A drain word during the pixel phase is ignored.
         if (!drain && mode) return;
         top = upper_row[col];
         mid = middle_row[col];
         bot = drain ? 24'd0 : {r, g, b};
         if (!drain) begin
            upper_row[col] = mid;
            middle_row[col] = bot;
         end
         for (int k = 0; k < 3; k++) begin
            win[k*3] = win[k*3+1];
            win[k*3+1] = win[k*3+2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = bot;
         emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (!emit || out_row >= h) return;
         // Average only the neighbors that lie inside the frame.
         acc = '{0, 0, 0};
         n = 0;
         re = out_col + 1 >= w;
         fe = re && out_row + 1 >= h;
         for (int dr = 0; dr < 3; dr++) begin
            if ((dr == 0 && out_row == 0) || (dr == 2 && out_row + 1 >= h)) continue;
            for (int dc = 0; dc < 3; dc++) begin
               if ((dc == 0 && out_col == 0) || (dc == 2 && out_col + 1 >= w)) continue;
               p = win[dr*3+dc];
               acc[0] += p[23:16];
               acc[1] += p[15:8];
               acc[2] += p[7:0];
               n++;
            end
         end
         e.red = 8'((acc[0] + n/2) / n);
         e.green = 8'((acc[1] + n/2) / n);
         e.blue = 8'((acc[2] + n/2) / n);
         e.row_end = re;
         e.frame_end = fe;
         due_words.push_back(e);
         if (fe) begin
            restart();
         end else begin
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               out_row++;
            end
         end
      endfunction

      // Compare a popped word with the oldest prediction.
      function void check_word(blur_word_type got);
         blur_word_type e;
         if (due_words.size() == 0) begin
            $error("unexpected output word");
            errors++;
            return;
         end
         e = due_words.pop_front();
         if (got.red != e.red) begin
            $error("out_red: expected %0d, got %0d", e.red, got.red);
            errors++;
         end
         if (got.green != e.green) begin
            $error("out_green: expected %0d, got %0d", e.green, got.green);
            errors++;
         end
         if (got.blue != e.blue) begin
            $error("out_blue: expected %0d, got %0d", e.blue, got.blue);
            errors++;
         end
         if (got.row_end != e.row_end) begin
            $error("row_end: expected %0d, got %0d", e.row_end, got.row_end);
            errors++;
         end
         if (got.frame_end != e.frame_end) begin
            $error("frame_end: expected %0d, got %0d", e.frame_end, got.frame_end);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic full;
   logic req_mode = 0;
   logic [7:0] req_pixel_red = 0;
   logic [7:0] req_pixel_green = 0;
   logic [7:0] req_pixel_blue = 0;
   logic empty;
   logic pop = 0;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic rsp_row_end, rsp_frame_end;
   logic csr_write = 0;
   logic [bb3_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [bb3_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   blur_scoreboard sb = new();
   bit calm;
   int items_sent, words_popped, frames_seen;

   always #4 clock = ~clock;

   box_blur_3x3_rgb_core dut (.*);

   // Send one input word after a random gap (none when calm is set); push stays high across back-to-back words.
   task automatic send_word(bit mode, bit [7:0] r, bit [7:0] g, bit [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(7);
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      push <= 1;
      req_mode <= mode;
      req_pixel_red <= r;
      req_pixel_green <= g;
      req_pixel_blue <= b;
      do @(posedge clock); while (full);
      sb.note_word(mode, r, g, b);
      items_sent++;
   endtask

   // Wait until every predicted word is out and the pipeline is quiet, then set the frame size.
   task automatic set_frame(bit [bb3_pkg::CSR_DATA_BITS-1:0] w,
                            bit [bb3_pkg::CSR_DATA_BITS-1:0] h);
      push <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_write <= 1;
      csr_index <= bb3_pkg::REG_FRAME_WIDTH;
      csr_data <= w;
      @(posedge clock);
      sb.write_reg(bb3_pkg::REG_FRAME_WIDTH, w);
      csr_index <= bb3_pkg::REG_FRAME_HEIGHT;
      csr_data <= h;
      @(posedge clock);
      sb.write_reg(bb3_pkg::REG_FRAME_HEIGHT, h);
      csr_write <= 0;
   endtask

   // One frame of random pixels and drain words, cut short if cut > 0; noise adds stray words of both kinds.
   task automatic run_frame(int w, int h, bit noise, int cut);
      for (int i = 0; i < w*h; i++) begin
         if (cut > 0 && i == cut) return;
         if (noise && $urandom_range(7) == 0)
            send_word(1, $urandom, $urandom, $urandom);
         send_word(0, $urandom, $urandom, $urandom);
      end
      for (int i = 0; i <= w; i++)
         send_word((noise && $urandom_range(3) == 0) ? 1'b0 : 1'b1, $urandom, $urandom, $urandom);
   endtask

   // Receiver: pop with random stalls and check each word.
   initial begin
      blur_word_type got;
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = calm ? 0 : $urandom_range(7);
         if (gap > 0) begin
            pop <= 0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1;
         do @(posedge clock); while (empty);
         got.red = rsp_out_red;
         got.green = rsp_out_green;
         got.blue = rsp_out_blue;
         got.row_end = rsp_row_end;
         got.frame_end = rsp_frame_end;
         sb.check_word(got);
         words_popped++;
         if (rsp_frame_end) frames_seen++;
      end
   end

   // Main sequence.
   initial begin
      bit [7:0] edge_vals [6];
      int w, h;
      edge_vals = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFF, 8'h00};
      items_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: a 3x3 frame of extreme values, a stray drain word, a pixel in the drain.
      set_frame(3, 3);
      send_word(1, 8'hFF, 8'hFF, 8'hFF);
      for (int i = 0; i < 9; i++)
         send_word(0, edge_vals[i%6], edge_vals[(i+2)%6], edge_vals[(i+4)%6]);
      send_word(0, 8'hFF, 8'hFF, 8'hFF);
      for (int i = 0; i < 3; i++) send_word(1, 8'h00, 8'h00, 8'h00);

      // Register extremes, out-of-range values that clamp included; large frames cut short.
      set_frame(1, 1);
      run_frame(1, 1, 0, 0);
      set_frame(0, 0);
      run_frame(1, 1, 1, 0);
      set_frame(1, 3);
      run_frame(1, 3, 0, 0);
      set_frame(4, 1);
      run_frame(4, 1, 1, 0);
      set_frame(11'h7FF, 13'h1FFF);
      run_frame(1024, 4096, 0, 1026);
      set_frame(1, 13'h1FFF);
      run_frame(1, 4096, 0, 120);
      set_frame(2, 4096);
      run_frame(2, 4096, 0, 60);

      // Random small frames, some back to back, some cut short and dropped.
      while (items_sent < 1800) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 10);
         calm = $urandom_range(4) == 0;
         set_frame(w, h);
         for (int f = $urandom_range(1, 3); f > 0; f--)
            run_frame(w, h, $urandom_range(2) == 0,
                      ($urandom_range(9) == 0) ? $urandom_range(1, w*h) : 0);
      end
      calm = 0;

      push <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      $display("Sent %0d input words and checked %0d blurred words over %0d complete frames,",
               items_sent, words_popped, frames_seen);
      $display("covering clamped sizes, one-pixel rows and columns, and random frames up to 12x10.");
      if (sb.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
